FILE: sv/ieee_cvt_pkg.sv
// Package with the format codes and binary64 constants of the float converter.
`default_nettype none
package ieee_cvt_pkg;
   typedef enum logic [1:0] {
      FMT_SINGLE   = 2'd0,
      FMT_DOUBLE   = 2'd1,
      FMT_EXTENDED = 2'd2,
      FMT_INVALID  = 2'd3
   } format_type;

   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] INF64  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] DMAX64 = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam logic [63:0] DMIN64 = 64'h0010_0000_0000_0000;
endpackage
`default_nettype wire

FILE: sv/ieee_float_to_double_convert.sv
// Top level of the binary32/binary64/extended80 to binary64 converter.
//
// Usage: raise start with req_format, req_raw_head and req_raw_tail; the item is
// accepted at an edge where start is high and busy is low. busy is always low,
// so a new item may enter every cycle. Each result appears on rsp_result_bits
// and rsp_bad_format for exactly one cycle, marked by rsp_valid, in order.
// The item passes the stage 1, 2 and 3 registers in order, and rsp_valid is
// registered from the stage 3 valid bit.
// Throughput is one item per cycle: four register stages (unpack, leading-zero
// count, normalize and round, pack) each take one item per cycle.
// The byte order register is written over csr_valid/csr_ready; the user must
// write it only while the block is idle, which the block does not enforce.
// csr_ready is always high. Reset clears all valid bits and sets byte order to
// big-endian. The receiver cannot stall the result channel.
`default_nettype none
module ieee_float_to_double_convert (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire ieee_cvt_pkg::format_type req_format,
   input  wire logic [63:0]              req_raw_head,
   input  wire logic [15:0]              req_raw_tail,
   output logic                          rsp_valid,
   output logic [63:0]                   rsp_result_bits,
   output logic                          rsp_bad_format,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_byte_order
);
   import ieee_cvt_pkg::*;

   logic order_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         order_ff <= csr_byte_order;
      end
   end
   assign csr_ready = 1'b1;
   assign busy = 1'b0;

   // Stage 1: byte reorder, field extraction, special cases.
   logic [7:0]  b [10];
   logic [7:0]  s [10];
   logic        v1_in, neg1_in, spec1_in;
   logic [63:0] spec_bits1_in, mag1_in;
   logic signed [13:0] scale1_in;
   logic        bad1_in;
   logic [14:0] ee;
   logic [10:0] ee_off;
   logic [10:0] ed;
   logic [7:0]  es;

   always_comb begin
      for (int i = 0; i < 8; i++) b[i] = req_raw_head[63-8*i -: 8];
      b[8] = req_raw_tail[15:8];
      b[9] = req_raw_tail[7:0];
      for (int i = 0; i < 10; i++) s[i] = b[i];
      if (order_ff) begin
         unique case (req_format)
            FMT_SINGLE:   for (int i = 0; i < 4; i++) s[i] = b[3-i];
            FMT_DOUBLE:   for (int i = 0; i < 8; i++) s[i] = b[7-i];
            default:      for (int i = 0; i < 10; i++) s[i] = b[9-i];
         endcase
      end
      v1_in = start && !busy;
      neg1_in = s[0][7];
      bad1_in = 1'b0;
      spec1_in = 1'b1;
      spec_bits1_in = neg1_in ? SIGN64 : 64'd0;
      mag1_in = '0;
      scale1_in = '0;
      es = {s[0][6:0], s[1][7]};
      ed = {s[0][6:0], s[1][7:4]};
      ee = {s[0][6:0], s[1]};
      ee_off = 11'(ee - 15'd15360);
      unique case (req_format)
         FMT_SINGLE: begin
            mag1_in = {40'd0, (es != 8'd0), s[1][6:0], s[2], s[3]};
            if (es == 8'hFF) begin
               spec_bits1_in = (mag1_in[22:0] == 23'd0) ?
                  (INF64 | (neg1_in ? SIGN64 : 64'd0)) : QNAN64;
            end else if (mag1_in != 64'd0) begin
               spec1_in = 1'b0;
               scale1_in = (es == 8'd0) ? -14'sd149
                  : $signed({6'd0, es}) - 14'sd150;
            end
         end
         FMT_DOUBLE: begin
            mag1_in = {11'd0, (ed != 11'd0), s[1][3:0], s[2], s[3], s[4], s[5],
                       s[6], s[7]};
            if (ed == 11'h7FF) begin
               spec_bits1_in = (mag1_in[51:0] == 52'd0) ?
                  (INF64 | (neg1_in ? SIGN64 : 64'd0)) : QNAN64;
            end else if (mag1_in != 64'd0) begin
               spec1_in = 1'b0;
               scale1_in = (ed == 11'd0) ? -14'sd1074
                  : $signed({3'd0, ed}) - 14'sd1075;
            end
         end
         FMT_EXTENDED: begin
            mag1_in = {s[2], s[3], s[4], s[5], s[6], s[7], s[8], s[9]};
            if (ee == 15'd0) begin
               spec_bits1_in = neg1_in ? SIGN64 : 64'd0;
            end else if (ee == 15'h7FFF) begin
               spec_bits1_in = (mag1_in[62:0] == 63'd0) ?
                  (INF64 | (neg1_in ? SIGN64 : 64'd0)) : QNAN64;
            end else if (ee >= 15'd17407) begin
               spec_bits1_in = DMAX64 | (neg1_in ? SIGN64 : 64'd0);
            end else if (ee < 15'd15361) begin
               spec_bits1_in = DMIN64 | (neg1_in ? SIGN64 : 64'd0);
            end else if (mag1_in != 64'd0) begin
               spec1_in = 1'b0;
               scale1_in = $signed({3'd0, ee_off}) - 14'sd1086;
            end
         end
         default: begin
            bad1_in = 1'b1;
            spec_bits1_in = 64'd0;
         end
      endcase
   end

   logic        v1_ff, neg1_ff, spec1_ff, bad1_ff;
   logic [63:0] spec_bits1_ff, mag1_ff;
   logic signed [13:0] scale1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v1_in;
      neg1_ff <= neg1_in;
      spec1_ff <= spec1_in;
      bad1_ff <= bad1_in;
      spec_bits1_ff <= spec_bits1_in;
      mag1_ff <= mag1_in;
      scale1_ff <= scale1_in;
   end

   // Stage 2: leading-zero count and normalizing shift.
   logic [5:0]  lz2_in;
   logic [63:0] norm2_in;
   always_comb begin
      lz2_in = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (mag1_ff[i]) lz2_in = 6'(63 - i);
      end
      norm2_in = mag1_ff << lz2_in;
   end

   logic        v2_ff, neg2_ff, spec2_ff, bad2_ff;
   logic [63:0] spec_bits2_ff, norm2_ff;
   logic signed [13:0] be2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      neg2_ff <= neg1_ff;
      spec2_ff <= spec1_ff;
      bad2_ff <= bad1_ff;
      spec_bits2_ff <= spec_bits1_ff;
      norm2_ff <= norm2_in;
      be2_ff <= scale1_ff - $signed({8'd0, lz2_in}) + 14'sd1086;
   end

   // Stage 3: denormalizing shift and round to nearest even.
   logic [6:0]   sh3;
   logic [127:0] wide3;
   logic [63:0]  kept3, rem3, half3;
   logic [53:0]  kept3_in;
   logic         zero3_in;
   always_comb begin
      if (be2_ff < 14'sd1) begin
         sh3 = (be2_ff < -14'sd52) ? 7'd65 : 7'(14'sd12 - be2_ff);
      end else begin
         sh3 = 7'd11;
      end
      zero3_in = (sh3 > 7'd64);
      wide3 = {norm2_ff, 64'd0} >> sh3;
      kept3 = wide3[127:64];
      rem3 = wide3[63:0];
      half3 = 64'h8000_0000_0000_0000;
      kept3_in = kept3[53:0];
      if (rem3 > half3 || (rem3 == half3 && kept3[0])) kept3_in = kept3[53:0] + 54'd1;
   end

   logic        v3_ff, neg3_ff, spec3_ff, bad3_ff, zero3_ff;
   logic [63:0] spec_bits3_ff;
   logic [53:0] kept3_ff;
   logic signed [13:0] be3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      neg3_ff <= neg2_ff;
      spec3_ff <= spec2_ff;
      bad3_ff <= bad2_ff;
      zero3_ff <= zero3_in;
      spec_bits3_ff <= spec_bits2_ff;
      kept3_ff <= kept3_in;
      be3_ff <= be2_ff;
   end

   // Stage 4: exponent adjust and packing.
   logic [63:0] bits4;
   logic [53:0] k4;
   logic signed [13:0] e4;
   always_comb begin
      k4 = kept3_ff;
      e4 = be3_ff;
      if (zero3_ff) begin
         bits4 = 64'd0;
      end else if (be3_ff >= 14'sd1) begin
         if (k4[53]) begin
            k4 = k4 >> 1;
            e4 = e4 + 14'sd1;
         end
         bits4 = (e4 >= 14'sd2047) ? INF64 : {1'b0, e4[10:0], k4[51:0]};
      end else begin
         bits4 = {10'd0, k4};
      end
      if (neg3_ff) bits4 = bits4 | SIGN64;
      if (spec3_ff) bits4 = spec_bits3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= v3_ff;
      rsp_result_bits <= bits4;
      rsp_bad_format <= bad3_ff;
   end

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_format |-> rsp_result_bits == 64'd0)
      else $error("bad format result not zero");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> ##2 rsp_valid)
      else $error("item lost in pipeline");
   a_norm: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !spec2_ff |-> norm2_ff[63])
      else $error("mantissa not normalized");
endmodule
`default_nettype wire

FILE: bench/ieee_float_to_double_convert_test.sv
// Self-checking testbench for the float to binary64 converter: directed and random items.
`timescale 1ns / 100ps
module ieee_float_to_double_convert_test;
   import ieee_cvt_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [63:0] bits;
      logic        bad;
   } conv_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   format_type  req_format;
   logic [63:0] req_raw_head;
   logic [15:0] req_raw_tail;
   logic        rsp_valid;
   logic [63:0] rsp_result_bits;
   logic        rsp_bad_format;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_byte_order;

   conv_result_type expected_results[$];
   logic         byte_order_model;
   int           sender_idle_pct;
   int           error_count;
   int           checked_count;
   int           idle_cycles;
   int           format_count[4];

   ieee_float_to_double_convert dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_format     (req_format),
      .req_raw_head   (req_raw_head),
      .req_raw_tail   (req_raw_tail),
      .rsp_valid      (rsp_valid),
      .rsp_result_bits(rsp_result_bits),
      .rsp_bad_format (rsp_bad_format),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_byte_order (csr_byte_order)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Rounds mag * 2^scale once to binary64, ties to even.
   function automatic logic [63:0] round_to_double(input logic neg, input logic [63:0] mag,
                                                   input int scale);
      int          lz;
      int          be;
      int          shift;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] bits;
      lz = 0;
      while (mag[63] == 1'b0) begin
         mag = mag << 1;
         lz++;
      end
      be = scale - lz + 63 + 1023;
      shift = 11;
      if (be < 1) shift = 11 + (1 - be);
      if (shift > 64) begin
         bits = '0;
      end else begin
         if (shift < 64) begin
            kept = mag >> shift;
            rem = mag & ((64'd1 << shift) - 64'd1);
         end else begin
            kept = '0;
            rem = mag;
         end
         half = 64'd1 << (shift - 1);
         if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
         if (be >= 1) begin
            if (kept == (64'd1 << 53)) begin
               kept = kept >> 1;
               be++;
            end
            if (be >= 2047) bits = INF64;
            else bits = {1'b0, 11'(be), kept[51:0]};
         end else begin
            bits = kept;
         end
      end
      return neg ? (bits | SIGN64) : bits;
   endfunction

   function automatic conv_result_type convert_value(input format_type fmt,
                                                     input logic [63:0] head,
                                                     input logic [15:0] tail,
                                                     input logic order);
      conv_result_type r;
      logic [7:0]   b[10];
      logic [7:0]   t;
      logic [79:0]  word;
      logic         neg;
      int           n;
      int           e;
      logic [63:0]  m;
      r.bad = 1'b0;
      r.bits = '0;
      if (fmt == FMT_INVALID) begin
         r.bad = 1'b1;
         return r;
      end
      for (int i = 0; i < 8; i++) b[i] = head[63 - 8 * i -: 8];
      b[8] = tail[15:8];
      b[9] = tail[7:0];
      n = (fmt == FMT_SINGLE) ? 4 : (fmt == FMT_DOUBLE) ? 8 : 10;
      if (order) begin
         for (int i = 0; i < n / 2; i++) begin
            t = b[i];
            b[i] = b[n - 1 - i];
            b[n - 1 - i] = t;
         end
      end
      for (int i = 0; i < 10; i++) word[79 - 8 * i -: 8] = b[i];
      neg = word[79];
      if (fmt == FMT_SINGLE) begin
         e = word[78:71];
         m = {41'd0, word[70:48]};
         if (e == 0)
            r.bits = (m == 0) ? {neg, 63'd0} : round_to_double(neg, m, -149);
         else if (e == 255)
            r.bits = (m == 0) ? (INF64 | {neg, 63'd0}) : QNAN64;
         else
            r.bits = round_to_double(neg, m | (64'd1 << 23), e - 150);
      end else if (fmt == FMT_DOUBLE) begin
         e = word[78:68];
         m = {12'd0, word[67:16]};
         if (e == 0)
            r.bits = (m == 0) ? {neg, 63'd0} : round_to_double(neg, m, -1074);
         else if (e == 2047)
            r.bits = (m == 0) ? (INF64 | {neg, 63'd0}) : QNAN64;
         else
            r.bits = round_to_double(neg, m | (64'd1 << 52), e - 1075);
      end else begin
         e = word[78:64];
         m = word[63:0];
         if (e == 0) r.bits = {neg, 63'd0};
         else if (e == 32767) r.bits = (m[62:0] == 0) ? (INF64 | {neg, 63'd0}) : QNAN64;
         else if (e - 16383 >= 1024) r.bits = DMAX64 | {neg, 63'd0};
         else if (e - 16383 < -1022) r.bits = DMIN64 | {neg, 63'd0};
         else if (m == 0) r.bits = {neg, 63'd0};
         else r.bits = round_to_double(neg, m, e - 16383 - 63);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_result_bits, 64'd0);
         end else begin
            want = expected_results.pop_front();
            checked_count++;
            if (rsp_result_bits !== want.bits)
               report_mismatch("result_bits", rsp_result_bits, want.bits);
            if (rsp_bad_format !== want.bad)
               report_mismatch("bad_format", {63'd0, rsp_bad_format}, {63'd0, want.bad});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Places the logical bytes of a number in the stored order; unused bytes are random.
   task automatic send_number(input format_type fmt, input logic [79:0] word);
      logic [7:0] sb[10];
      int         n;
      for (int i = 0; i < 10; i++) sb[i] = 8'($urandom);
      n = (fmt == FMT_SINGLE) ? 4 : (fmt == FMT_DOUBLE) ? 8 : 10;
      if (fmt != FMT_INVALID)
         for (int i = 0; i < n; i++)
            sb[byte_order_model ? n - 1 - i : i] = word[79 - 8 * i -: 8];
      send_item(fmt, {sb[0], sb[1], sb[2], sb[3], sb[4], sb[5], sb[6], sb[7]}, {sb[8], sb[9]});
   endtask

   task automatic send_item(input format_type fmt, input logic [63:0] head,
                            input logic [15:0] tail);
      start <= 1'b1;
      req_format <= fmt;
      req_raw_head <= head;
      req_raw_tail <= tail;
      do @(posedge clock); while (busy);
      expected_results.push_back(convert_value(fmt, head, tail, byte_order_model));
      format_count[fmt]++;
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_byte_order(input logic order);
      wait_drained();
      csr_valid <= 1'b1;
      csr_byte_order <= order;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      byte_order_model = order;
   endtask

   task automatic send_random_number();
      logic [79:0] w;
      int          pick;
      int          e;
      logic [63:0] m;
      w = {$urandom, $urandom, 16'($urandom)};
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_number(FMT_INVALID, w);
      end else if (pick < 38) begin
         case ($urandom_range(5))
            0: w[78:71] = 8'd0;
            1: w[78:71] = 8'd255;
            2: w[78:71] = 8'($urandom_range(2) == 0 ? 1 : 254);
            default: ;
         endcase
         if ($urandom_range(5) == 0) w[70:48] = '0;
         send_number(FMT_SINGLE, w);
      end else if (pick < 68) begin
         case ($urandom_range(5))
            0: w[78:68] = 11'd0;
            1: w[78:68] = 11'd2047;
            2: w[78:68] = 11'($urandom_range(2) == 0 ? 1 : 2046);
            default: ;
         endcase
         if ($urandom_range(5) == 0) w[67:16] = '0;
         send_number(FMT_DOUBLE, w);
      end else begin
         case ($urandom_range(7))
            0: e = 0;
            1: e = 32767;
            2: e = 16383 + 1023 + $urandom_range(1);
            3: e = 16383 - 1022 - $urandom_range(1);
            4: e = $urandom_range(32766, 1);
            default: e = $urandom_range(16383 + 1023, 16383 - 1022);
         endcase
         w[78:64] = 15'(e);
         m = w[63:0];
         case ($urandom_range(5))
            0: m[63] = 1'b0;
            1: m = m >> $urandom_range(63);
            2: m = '0;
            3: m = ($urandom_range(1) == 0) ? '1 : 64'h8000_0000_0000_0000;
            default: ;
         endcase
         w[63:0] = m;
         send_number(FMT_EXTENDED, w);
      end
   endtask

   task automatic test_special_values();
      send_number(FMT_INVALID, '1);
      send_number(FMT_SINGLE, {32'h0000_0000, 48'd0});
      send_number(FMT_SINGLE, {32'h8000_0000, 48'd0});
      send_number(FMT_SINGLE, {32'h0000_0001, 48'd0});
      send_number(FMT_SINGLE, {32'h807F_FFFF, 48'd0});
      send_number(FMT_SINGLE, {32'h7F7F_FFFF, 48'd0});
      send_number(FMT_SINGLE, {32'hFF80_0000, 48'd0});
      send_number(FMT_SINGLE, {32'h7FC0_0001, 48'd0});
      send_number(FMT_DOUBLE, {64'h0000_0000_0000_0001, 16'd0});
      send_number(FMT_DOUBLE, {64'hFFEF_FFFF_FFFF_FFFF, 16'd0});
      send_number(FMT_DOUBLE, {64'h7FF0_0000_0000_0000, 16'd0});
      send_number(FMT_DOUBLE, {64'hFFF0_0000_0000_0001, 16'd0});
      send_number(FMT_EXTENDED, {16'h8000, 64'hFFFF_FFFF_FFFF_FFFF});
      send_number(FMT_EXTENDED, {16'hFFFF, 64'h0000_0000_0000_0000});
      send_number(FMT_EXTENDED, {16'h7FFF, 64'hC000_0000_0000_0000});
      send_number(FMT_EXTENDED, {16'h43FF, 64'h8000_0000_0000_0000});
      send_number(FMT_EXTENDED, {16'hBC00, 64'h8000_0000_0000_0000});
      send_number(FMT_EXTENDED, {16'h3C01, 64'h0000_0000_0000_0000});
      send_number(FMT_EXTENDED, {16'h3C01, 64'h0000_0000_0000_0001});
      send_number(FMT_EXTENDED, {16'h43FE, 64'hFFFF_FFFF_FFFF_FFFF});
      send_number(FMT_EXTENDED, {16'h3FFF, 64'h8000_0000_0000_0C00});
      send_number(FMT_EXTENDED, {16'h3FFF, 64'h8000_0000_0000_0400});
   endtask

   task automatic test_byte_reversal();
      write_byte_order(1'b1);
      send_number(FMT_SINGLE, {32'h3F80_0001, 48'd0});
      send_number(FMT_DOUBLE, {64'hC00A_BCDE_F012_3456, 16'd0});
      send_number(FMT_EXTENDED, {16'hC000, 64'hABCD_EF01_2345_6789});
      send_number(FMT_INVALID, '0);
   endtask

   task automatic test_random_phase(input logic order, input int idle_pct, input int count);
      write_byte_order(order);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         send_random_number();
         if (i == count / 2 && idle_pct == 0) wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_format = FMT_SINGLE;
      req_raw_head = '0;
      req_raw_tail = '0;
      csr_valid = 1'b0;
      csr_byte_order = 1'b0;
      byte_order_model = 1'b0;
      sender_idle_pct = 0;
      error_count = 0;
      checked_count = 0;
      idle_cycles = 0;
      for (int i = 0; i < 4; i++) format_count[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_byte_reversal();
      test_random_phase(1'b0, 0, 260);
      test_random_phase(1'b1, 70, 260);
      test_random_phase(1'b0, 10, 260);
      test_random_phase(1'b1, 0, 270);
      wait_drained();
      $display("Covered %0d single, %0d double, %0d extended and %0d invalid items,",
               format_count[FMT_SINGLE], format_count[FMT_DOUBLE],
               format_count[FMT_EXTENDED], format_count[FMT_INVALID]);
      $display("both byte orders; %0d results checked, %0d mismatches.",
               checked_count, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
